### design/assert_macros.svh
// Shared assertion macros for the elevator next-floor selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/elev_pkg.sv
package elev_pkg;

  localparam int FLOORS_DEF = 7;
  localparam int FLOORS_MAX = 16;
  // floor number 0..FLOORS_MAX, 0 = none found
  localparam int FNUM_W     = 5;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;

  // Lowest set bit as a 1-based floor number, 0 if mask is empty.
  function automatic logic [FNUM_W-1:0] lowest_floor(input logic [FLOORS_MAX-1:0] m);
    logic [FNUM_W-1:0] r;
    r = '0;
    for (int i = FLOORS_MAX - 1; i >= 0; i--) begin
      if (m[i]) r = FNUM_W'(i + 1);
    end
    return r;
  endfunction

  // Highest set bit as a 1-based floor number, 0 if mask is empty.
  function automatic logic [FNUM_W-1:0] highest_floor(input logic [FLOORS_MAX-1:0] m);
    logic [FNUM_W-1:0] r;
    r = '0;
    for (int i = 0; i < FLOORS_MAX; i++) begin
      if (m[i]) r = FNUM_W'(i + 1);
    end
    return r;
  endfunction

endpackage

### design/elev_ifs.sv
// Request channel: car position, motion and call bits.
interface elev_req_if #(
  parameter int FLOORS = elev_pkg::FLOORS_DEF
);
  localparam int FW = $clog2(FLOORS + 1);

  logic                  valid;
  logic                  ready;
  logic [FW-1:0]         car_floor;
  logic [1:0]            direction;
  logic [2*FLOORS-1:0]   hall_calls;
  logic [FLOORS-1:0]     car_calls;

  modport source (output valid, car_floor, direction, hall_calls, car_calls,
                  input ready);
  modport sink   (input valid, car_floor, direction, hall_calls, car_calls,
                  output ready);
endinterface

// Result channel: floor to serve next.
interface elev_res_if #(
  parameter int FLOORS = elev_pkg::FLOORS_DEF
);
  localparam int FW = $clog2(FLOORS + 1);

  logic          valid;
  logic          ready;
  logic [FW-1:0] next_floor;

  modport source (output valid, next_floor, input ready);
  modport sink   (input valid, next_floor, output ready);
endinterface

### design/elevator_next_floor_select.sv
// Next-floor selector for one elevator car, SCAN order. Takes one request item
// per cycle while not stalled (floor, direction, hall and car calls) and
// returns one next_floor item for each, in order. From acceptance to out valid
// an item passes an input register, then the floor search (fixed priority
// encoders across FLOORS floors) into the result register. Throughput is one
// item per cycle; the result register holds while the result side holds ready
// low, and the input stage still fills if empty, then stalls too. No state
// beyond the pipeline; no configuration.
module elevator_next_floor_select #(
  parameter int FLOORS = elev_pkg::FLOORS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  elev_req_if.sink    in_req,
  elev_res_if.source  out_res
);

  localparam int FW = $clog2(FLOORS + 1);

  // input stage
  logic                s1_v_r, s1_v_nxt;
  logic [FW-1:0]       s1_cur_r;
  logic [1:0]          s1_dir_r;
  logic [2*FLOORS-1:0] s1_hall_r;
  logic [FLOORS-1:0]   s1_car_r;

  // result stage
  logic                out_v_r, out_v_nxt;
  logic [FW-1:0]       out_nf_r;

  logic                s1_rdy, s2_rdy, in_acc;
  logic [FW-1:0]       nf_comb;

  // result register free or draining this cycle
  assign s2_rdy = !out_v_r || out_res.ready;
  // input register free or moving forward this cycle
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_acc = in_req.valid && s1_rdy;

  assign in_req.ready = s1_rdy;

  assign s1_v_nxt  = s1_rdy ? in_req.valid : s1_v_r;
  assign out_v_nxt = s2_rdy ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r  <= in_req.car_floor;
      s1_dir_r  <= in_req.direction;
      s1_hall_r <= in_req.hall_calls;
      s1_car_r  <= in_req.car_calls;
    end
    if (s2_rdy && s1_v_r) begin
      out_nf_r <= nf_comb;
    end
  end

  elev_search #(.FLOORS(FLOORS)) u_search (
    .cur_floor  (s1_cur_r),
    .direction  (s1_dir_r),
    .hall_calls (s1_hall_r),
    .car_calls  (s1_car_r),
    .next_floor (nf_comb)
  );

  assign out_res.valid      = out_v_r;
  assign out_res.next_floor = out_nf_r;

endmodule

### design/elev_search.sv
// Priority search for the next floor; purely combinational.
module elev_search #(
  parameter int FLOORS = elev_pkg::FLOORS_DEF,
  localparam int FW    = $clog2(FLOORS + 1)
) (
  input  logic [FW-1:0]       cur_floor,
  input  logic [1:0]          direction,
  input  logic [2*FLOORS-1:0] hall_calls,
  input  logic [FLOORS-1:0]   car_calls,
  output logic [FW-1:0]       next_floor
);

  localparam int FMAX = elev_pkg::FLOORS_MAX;
  localparam int NW   = elev_pkg::FNUM_W;

  logic [FMAX-1:0] above, below, w_up, w_dn, dn_only, up_only, any_call;
  logic [NW-1:0]   cur_ext;
  logic [NW-1:0]   up_near, dn_only_hi, dn_near, up_only_lo, stop_lo, pick;

  assign cur_ext = NW'(cur_floor);

  always_comb begin
    above    = '0;
    below    = '0;
    w_up     = '0;
    w_dn     = '0;
    dn_only  = '0;
    up_only  = '0;
    any_call = '0;
    for (int i = 0; i < FLOORS; i++) begin
      above[i]    = NW'(i + 1) > cur_ext;
      below[i]    = NW'(i + 1) < cur_ext;
      w_up[i]     = hall_calls[2*i] | car_calls[i];
      w_dn[i]     = hall_calls[2*i+1] | car_calls[i];
      dn_only[i]  = hall_calls[2*i+1] & ~hall_calls[2*i];
      up_only[i]  = hall_calls[2*i] & ~hall_calls[2*i+1];
      any_call[i] = hall_calls[2*i] | hall_calls[2*i+1] | car_calls[i];
    end
  end

  assign up_near    = elev_pkg::lowest_floor(w_up & above);
  assign dn_only_hi = elev_pkg::highest_floor(dn_only & above);
  assign dn_near    = elev_pkg::highest_floor(w_dn & below);
  assign up_only_lo = elev_pkg::lowest_floor(up_only & below);
  assign stop_lo    = elev_pkg::lowest_floor(any_call);

  always_comb begin
    pick = '0;
    case (direction)
      elev_pkg::DIR_STOP: begin
        pick = stop_lo;
      end
      elev_pkg::DIR_UP: begin
        pick = up_near;
        if (pick == '0) pick = dn_only_hi;
        if (pick == '0) pick = dn_near;
        if (pick == '0) pick = up_only_lo;
      end
      default: begin
        // down, and the unused code
        pick = dn_near;
        if (pick == '0) pick = up_only_lo;
        if (pick == '0) pick = up_near;
        if (pick == '0) pick = dn_only_hi;
      end
    endcase
  end

  assign next_floor = (pick == '0) ? cur_floor : FW'(pick);

endmodule

### design/elev_checker.sv
`include "assert_macros.svh"

module elev_checker #(
  parameter int FLOORS = elev_pkg::FLOORS_DEF,
  localparam int FW    = $clog2(FLOORS + 1)
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [FW-1:0]       in_cur,
  input logic [1:0]          in_dir,
  input logic [2*FLOORS-1:0] in_hall,
  input logic [FLOORS-1:0]   in_car,
  input logic                out_valid,
  input logic                out_ready,
  input logic [FW-1:0]       out_floor
);

  logic in_acc, out_free, idle_stop;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign idle_stop = in_acc && (in_dir == elev_pkg::DIR_STOP) && (in_hall == '0)
                     && (in_car == '0);

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_floor), "stalled result changed")
  `ASSERT_NXT_ALWAYS(a_rst_clear, clk, !rst_n, !out_valid, "result valid right after reset")
  `ASSERT_NXT(a_latency, clk, rst_n, in_acc ##1 out_free, out_valid, "result missing two cycles after accept")
  `ASSERT_NXT(a_idle_stay, clk, rst_n, idle_stop ##1 out_free, out_floor == $past(in_cur, 2), "idle car did not stay")

endmodule

bind elevator_next_floor_select elev_checker #(.FLOORS(FLOORS)) u_elev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .in_cur    (in_req.car_floor),
  .in_dir    (in_req.direction),
  .in_hall   (in_req.hall_calls),
  .in_car    (in_req.car_calls),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_floor (out_res.next_floor)
);

### dv/elevator_next_floor_select_test.sv
module elevator_next_floor_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FLOORS = elev_pkg::FLOORS_DEF;

  // Direction codes beyond the two the package names; both mean moving down.
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_ALT  = 2'd3;

  // Two-bit hall call code of one floor.
  localparam logic [1:0] HALL_NONE = 2'b00;
  localparam logic [1:0] HALL_UP   = 2'b01;
  localparam logic [1:0] HALL_DOWN = 2'b10;

  localparam int RANDOM_REQS  = 1050;
  localparam int TAIL_REQS    = 120;  // last items go without any idling
  localparam int LONG_HOLD    = 80;   // cycles the receiver backs off once
  localparam int HOLD_AT      = 400;  // accepted items before that hold-off
  localparam int DRAIN_AT     = 700;  // random item that waits for an empty pipe
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [2:0]  cur_floor;
    logic [1:0]  dir;
    logic [13:0] hall;
    logic [6:0]  car;
    bit          drain_first;  // sender waits until every result is back
  } call_req_t;

  logic clk;
  logic rst_n;

  elev_req_if #(.FLOORS(NUM_FLOORS)) req_if ();
  elev_res_if #(.FLOORS(NUM_FLOORS)) res_if ();

  elevator_next_floor_select #(.FLOORS(NUM_FLOORS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_res (res_if)
  );

  call_req_t   pending_reqs[$];
  logic [2:0]  expected_floors[$];
  int unsigned accepted_reqs  = 0;
  int unsigned fail_count     = 0;
  int unsigned send_gap       = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Prediction: SCAN search over the call bits of one request
  // ---------------------------------------------------------------------------

  // Hall code of floor f; floors outside 1..NUM_FLOORS carry no calls.
  function automatic logic [1:0] hall_code(input logic [13:0] hall, input int f);
    if (f < 1 || f > NUM_FLOORS) return HALL_NONE;
    return hall[2*(f-1) +: 2];
  endfunction

  function automatic bit car_req(input logic [6:0] car, input int f);
    if (f < 1 || f > NUM_FLOORS) return 1'b0;
    return car[f-1];
  endfunction

  function automatic bit wants_up(input logic [13:0] hall, input logic [6:0] car,
                                  input int f);
    return ((hall_code(hall, f) & HALL_UP) != HALL_NONE) || car_req(car, f);
  endfunction

  function automatic bit wants_down(input logic [13:0] hall, input logic [6:0] car,
                                    input int f);
    return ((hall_code(hall, f) & HALL_DOWN) != HALL_NONE) || car_req(car, f);
  endfunction

  function automatic logic [2:0] predict_next_floor(input logic [2:0] cur,
                                                    input logic [1:0] dir,
                                                    input logic [13:0] hall,
                                                    input logic [6:0] car);
    int c;
    int pick;
    int near_above;
    int top_down_only;
    int near_below;
    int low_up_only;
    c = cur;
    pick = 0;
    near_above = 0;
    top_down_only = 0;
    near_below = 0;
    low_up_only = 0;

    // stopped: lowest floor with any call, current floor included
    if (dir == elev_pkg::DIR_STOP) begin
      for (int f = NUM_FLOORS; f >= 1; f--) begin
        if (hall_code(hall, f) != HALL_NONE || car_req(car, f)) pick = f;
      end
      return (pick != 0) ? 3'(pick) : cur;
    end

    for (int f = c + 1; f <= NUM_FLOORS; f++) begin
      if (near_above == 0 && wants_up(hall, car, f)) near_above = f;
    end
    for (int f = NUM_FLOORS; f > c; f--) begin
      if (top_down_only == 0 && hall_code(hall, f) == HALL_DOWN) top_down_only = f;
    end
    for (int f = c - 1; f > 0; f--) begin
      if (near_below == 0 && wants_down(hall, car, f)) near_below = f;
    end
    for (int f = 1; f < c; f++) begin
      if (low_up_only == 0 && hall_code(hall, f) == HALL_UP) low_up_only = f;
    end

    // up searches above first; every other code mirrors it
    if (dir == elev_pkg::DIR_UP) begin
      pick = near_above;
      if (pick == 0) pick = top_down_only;
      if (pick == 0) pick = near_below;
      if (pick == 0) pick = low_up_only;
    end else begin
      pick = near_below;
      if (pick == 0) pick = low_up_only;
      if (pick == 0) pick = near_above;
      if (pick == 0) pick = top_down_only;
    end
    return (pick != 0) ? 3'(pick) : cur;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [13:0] up_bit(input int f);
    return 14'(1) << (2*(f-1));
  endfunction

  function automatic logic [13:0] dn_bit(input int f);
    return 14'(2) << (2*(f-1));
  endfunction

  task automatic add_req(input logic [2:0] cur, input logic [1:0] dir,
                         input logic [13:0] hall, input logic [6:0] car,
                         input bit drain_first);
    call_req_t r;
    r.cur_floor   = cur;
    r.dir         = dir;
    r.hall        = hall;
    r.car         = car;
    r.drain_first = drain_first;
    pending_reqs.push_back(r);
  endtask

  // Idling is off in the tail and in every third block of 128 items.
  function automatic bit idle_allowed();
    return pending_reqs.size() > TAIL_REQS && (accepted_reqs / 128) % 3 != 2;
  endfunction

  // ---------------------------------------------------------------------------
  // Reset and initial drive
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.car_floor  = '0;
    req_if.direction  = elev_pkg::DIR_STOP;
    req_if.hall_calls = '0;
    req_if.car_calls  = '0;
    res_if.ready      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, random gaps, one drain pause per marker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_reqs
    call_req_t nxt;
    bit        send;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      // item taken at this edge: predict its result now
      if (req_if.valid && req_if.ready) begin
        expected_floors.push_back(predict_next_floor(req_if.car_floor,
                                                     req_if.direction,
                                                     req_if.hall_calls,
                                                     req_if.car_calls));
        accepted_reqs++;
      end
      // payload may only change when nothing is on offer or it was just taken
      if (!req_if.valid || req_if.ready) begin
        send = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain_first && expected_floors.size() != 0)) begin
          if (idle_allowed() && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 12);
          end else begin
            nxt  = pending_reqs.pop_front();
            send = 1'b1;
            req_if.car_floor  <= nxt.cur_floor;
            req_if.direction  <= nxt.dir;
            req_if.hall_calls <= nxt.hall;
            req_if.car_calls  <= nxt.car;
          end
        end
        req_if.valid <= send;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction, drives ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    logic [2:0] want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_floors.size() == 0) begin
          $display("%0t: unexpected result next_floor=%0d, none expected",
                   $realtime, res_if.next_floor);
          fail_count++;
        end else begin
          want = expected_floors.pop_front();
          if (res_if.next_floor !== want) begin
            $display("%0t: next_floor mismatch, expected %0d, actual %0d",
                     $realtime, want, res_if.next_floor);
            fail_count++;
          end
        end
      end
      // one long back-off so the pipe fills and the input side stalls
      if (!long_hold_done && accepted_reqs >= HOLD_AT) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 12);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [2:0]  cur;
    logic [1:0]  dir;
    logic [13:0] hall;
    logic [6:0]  car;
    int          idx;

    // stopped: idle, current floor counts, all calls
    add_req(3'd4, elev_pkg::DIR_STOP, '0, '0, 1'b0);
    add_req(3'd4, elev_pkg::DIR_STOP, up_bit(6), 7'b0001000, 1'b0);
    add_req(3'd1, elev_pkg::DIR_STOP, 14'h3FFF, 7'h7F, 1'b0);
    // up: each of the four search steps
    add_req(3'd3, elev_pkg::DIR_UP, up_bit(5), 7'b0100000, 1'b0);
    add_req(3'd3, elev_pkg::DIR_UP, dn_bit(5) | dn_bit(6), '0, 1'b0);
    add_req(3'd5, elev_pkg::DIR_UP, dn_bit(2), 7'b0000001, 1'b0);
    add_req(3'd5, elev_pkg::DIR_UP, up_bit(2) | up_bit(3), '0, 1'b0);
    // both hall bits on a floor: counts as up and as down, never as one-kind
    add_req(3'd3, elev_pkg::DIR_UP, up_bit(6) | dn_bit(6), '0, 1'b0);
    add_req(3'd5, elev_pkg::DIR_UP, up_bit(2) | dn_bit(2), '0, 1'b0);
    add_req(3'd4, DIR_DOWN, up_bit(6) | dn_bit(6), '0, 1'b0);
    // down: mirror of the above
    add_req(3'd5, DIR_DOWN, up_bit(3), 7'b0000010, 1'b0);
    add_req(3'd5, DIR_DOWN, up_bit(1) | up_bit(3), '0, 1'b0);
    add_req(3'd2, DIR_DOWN, up_bit(4) | dn_bit(6), '0, 1'b0);
    add_req(3'd2, DIR_DOWN, dn_bit(3) | dn_bit(6), '0, 1'b0);
    // direction code three behaves as down
    add_req(3'd3, DIR_ALT, dn_bit(1) | up_bit(5), '0, 1'b0);
    add_req(3'd7, DIR_ALT, '0, 7'h7F, 1'b0);
    // floor zero: every floor lies above, nothing found gives zero
    add_req(3'd0, elev_pkg::DIR_UP, '0, '0, 1'b0);
    add_req(3'd0, DIR_DOWN, '0, 7'b1000000, 1'b0);
    add_req(3'd0, elev_pkg::DIR_STOP, up_bit(1), '0, 1'b0);
    add_req(3'd0, DIR_ALT, dn_bit(4), '0, 1'b0);
    // extremes: top, bottom and next-to-top floor, calls at the current floor only or on all floors
    add_req(3'd7, elev_pkg::DIR_UP, up_bit(7) | dn_bit(7), 7'b1000000, 1'b0);
    add_req(3'd7, elev_pkg::DIR_UP, 14'h3FFF, 7'h7F, 1'b0);
    add_req(3'd1, DIR_DOWN, 14'h3FFF, 7'h7F, 1'b0);
    add_req(3'd6, elev_pkg::DIR_UP, 14'h3FFF, '0, 1'b0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      cur  = ($urandom_range(0, 15) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      dir  = 2'($urandom_range(0, 3));
      hall = '0;
      car  = '0;
      case ($urandom_range(0, 3))
        0: begin
          hall = 14'($urandom);
          car  = 7'($urandom);
        end
        1: begin
          // sparse calls push the search past its first step
          hall = 14'($urandom & $urandom & $urandom);
          car  = 7'($urandom & $urandom & $urandom);
        end
        2: begin
          // one-kind hall calls, rarely both on one floor: reaches the second and fourth steps
          repeat ($urandom_range(1, 2)) begin
            idx = $urandom_range(1, NUM_FLOORS);
            hall |= ($urandom_range(0, 1) != 0) ? up_bit(idx) : dn_bit(idx);
          end
        end
        default: begin
          if ($urandom_range(0, 4) != 0) begin
            idx = $urandom_range(0, 20);
            if (idx < 14) hall[idx] = 1'b1;
            else car[idx-14] = 1'b1;
          end
        end
      endcase
      add_req(cur, dir, hall, car, (n == 0) || (n == DRAIN_AT));
    end

    wait (rst_n === 1'b1);
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_floors.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_floors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
